FILE: rtl/lsn_pkg.sv
package lsn_pkg;

  // Field and datapath widths.
  localparam int DATA_W       = 24;
  localparam int NORM_W       = 16;
  localparam int INV_W        = 32;
  localparam int DIFF_W       = 25;
  localparam int MAG_W        = 56;
  localparam int SMAG_W       = 30;
  localparam int SQ_W         = 2 * SMAG_W;
  localparam int SUM_W        = 64;
  localparam int LEN_W        = 31;
  localparam int QUOT_W       = 15;
  localparam int FRAC_W       = 14;
  localparam int NUM_W        = 46;
  localparam int SQRT_STEPS   = 31;
  localparam int SHIFT_W      = 6;
  localparam int NUM_AXES     = 3;
  localparam int DEF_NUM_DIMS = 3;
  localparam int ADDR_W       = 4;
  localparam int CFG_DATA_W   = 32;

  localparam logic [INV_W-1:0]  INV_RESET = 32'h0001_0000;
  localparam logic [QUOT_W-1:0] UNIT_NORM = 15'd16384;

  // Register indexes on the configuration port.
  typedef enum logic [1:0] {
    REG_INV_X = 2'd0,
    REG_INV_Y = 2'd1,
    REG_INV_Z = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] centre_value;
    logic signed [DATA_W-1:0] x_minus_value;
    logic signed [DATA_W-1:0] x_plus_value;
    logic signed [DATA_W-1:0] y_minus_value;
    logic signed [DATA_W-1:0] y_plus_value;
    logic signed [DATA_W-1:0] z_minus_value;
    logic signed [DATA_W-1:0] z_plus_value;
  } in_item_t;

  typedef struct packed {
    logic signed [NORM_W-1:0] normal_x;
    logic signed [NORM_W-1:0] normal_y;
    logic signed [NORM_W-1:0] normal_z;
    logic                     zero_gradient;
  } out_item_t;

  // Per-item data carried alongside the square root pipeline.
  typedef struct packed {
    logic [NUM_AXES-1:0][SMAG_W-1:0] mag;
    logic [NUM_AXES-1:0]             neg;
  } sq_side_t;

endpackage

FILE: rtl/lsn_lane.sv
module lsn_lane
  import lsn_pkg::*;
(
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [DATA_W-1:0] centre,
  input  logic signed [DATA_W-1:0] minus_val,
  input  logic signed [DATA_W-1:0] plus_val,
  input  logic [INV_W-1:0]         inv,
  output logic [MAG_W-1:0]         mag_r,
  output logic                     neg_r
);

  logic signed [DIFF_W-1:0] c_e, lo_e, hi_e, alo, ahi, diff;
  logic [DIFF_W-1:0]        adiff_nxt;
  logic [DIFF_W-1:0]        adiff_r;
  logic                     sgn_r;
  logic [DIFF_W+INV_W-1:0]  prod;

  // Pick the one-sided difference; ties take the backward difference.
  always_comb begin
    c_e  = DIFF_W'(centre);
    lo_e = DIFF_W'(minus_val);
    hi_e = DIFF_W'(plus_val);
    alo  = (lo_e < 0) ? -lo_e : lo_e;
    ahi  = (hi_e < 0) ? -hi_e : hi_e;
    diff = (ahi < alo) ? (hi_e - c_e) : (c_e - lo_e);
    adiff_nxt = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      adiff_r <= adiff_nxt;
      sgn_r   <= diff[DIFF_W-1];
    end
  end

  // Scale by the reciprocal cell size.
  assign prod = (DIFF_W+INV_W)'(adiff_r) * (DIFF_W+INV_W)'(inv);

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r <= prod[MAG_W-1:0];
      neg_r <= sgn_r;
    end
  end

endmodule

FILE: rtl/lsn_sqrt.sv
module lsn_sqrt
  import lsn_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [SUM_W-1:0] sum,
  input  sq_side_t         side,
  output logic             out_valid,
  output logic [LEN_W-1:0] len,
  output sq_side_t         side_out
);

  logic [SUM_W-1:0] s_r   [SQRT_STEPS];
  logic [SUM_W-1:0] res_r [SQRT_STEPS];
  sq_side_t         side_r [SQRT_STEPS];
  logic             v_r   [SQRT_STEPS];

  // One digit of the integer square root per stage.
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (2 * (SQRT_STEPS - 1 - k));
    logic [SUM_W-1:0] s_in, res_in, trial;
    sq_side_t         side_in;
    logic             v_in;

    if (k == 0) begin : g_first
      assign s_in    = sum;
      assign res_in  = '0;
      assign side_in = side;
      assign v_in    = in_valid;
    end else begin : g_next
      assign s_in    = s_r[k-1];
      assign res_in  = res_r[k-1];
      assign side_in = side_r[k-1];
      assign v_in    = v_r[k-1];
    end

    assign trial = res_in + BIT;

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[k] <= side_in;
        if (s_in >= trial) begin
          s_r[k]   <= s_in - trial;
          res_r[k] <= (res_in >> 1) + BIT;
        end else begin
          s_r[k]   <= s_in;
          res_r[k] <= res_in >> 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_in;
      end
    end
  end

  assign out_valid = v_r[SQRT_STEPS-1];
  assign len       = res_r[SQRT_STEPS-1][LEN_W-1:0];
  assign side_out  = side_r[SQRT_STEPS-1];

endmodule

FILE: rtl/lsn_div.sv
module lsn_div
  import lsn_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [SMAG_W-1:0] mag,
  input  logic [LEN_W-1:0]  len,
  input  logic              neg,
  output logic              out_valid,
  output logic [QUOT_W-1:0] quot,
  output logic              neg_out,
  output logic              zero_out
);

  logic [NUM_W-1:0]  rem_r  [QUOT_W];
  logic [LEN_W-1:0]  len_r  [QUOT_W];
  logic [QUOT_W-1:0] q_r    [QUOT_W];
  logic              neg_r  [QUOT_W];
  logic              zero_r [QUOT_W];
  logic              v_r    [QUOT_W];

  // Restoring division, one quotient bit per stage, most significant first.
  for (genvar k = 0; k < QUOT_W; k++) begin : g_step
    localparam int SH = QUOT_W - 1 - k;
    logic [NUM_W-1:0]  rem_in, dvs;
    logic [LEN_W-1:0]  len_in;
    logic [QUOT_W-1:0] q_in;
    logic              neg_in, zero_in, v_in;

    if (k == 0) begin : g_first
      // Numerator carries half the divisor so the quotient rounds half up.
      assign rem_in  = (NUM_W'(mag) << FRAC_W) + NUM_W'(len >> 1);
      assign len_in  = len;
      assign q_in    = '0;
      assign neg_in  = neg;
      assign zero_in = (len == '0);
      assign v_in    = in_valid;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign len_in  = len_r[k-1];
      assign q_in    = q_r[k-1];
      assign neg_in  = neg_r[k-1];
      assign zero_in = zero_r[k-1];
      assign v_in    = v_r[k-1];
    end

    assign dvs = NUM_W'(len_in) << SH;

    always_ff @(posedge clk) begin
      if (en) begin
        len_r[k]  <= len_in;
        neg_r[k]  <= neg_in;
        zero_r[k] <= zero_in;
        if (rem_in >= dvs) begin
          rem_r[k] <= rem_in - dvs;
          q_r[k]   <= q_in | (QUOT_W'(1) << SH);
        end else begin
          rem_r[k] <= rem_in;
          q_r[k]   <= q_in;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_in;
      end
    end
  end

  assign out_valid = v_r[QUOT_W-1];
  assign quot      = q_r[QUOT_W-1];
  assign neg_out   = neg_r[QUOT_W-1];
  assign zero_out  = zero_r[QUOT_W-1];

endmodule

FILE: rtl/level_set_normal_unit.sv
// Unit normal of a level set from one 7-point stencil.
// Input channel: in_valid / in_stall with in_item carrying the centre value
// and the minus and plus neighbours of each axis. Output channel: out_valid /
// out_stall with out_item carrying the Q1.14 normal and the zero flag.
// An item is taken at a clock edge where valid is high and stall is low.
// Throughput is one item per cycle while the output is not stalled. The
// pipeline runs through the axis lanes (difference, scaling multiply), the
// merge (maximum, shift count, normalize, square, sum), the square root
// with one root bit per stage, the dividers with one quotient bit per
// stage, and the output register.
// When the receiver stalls a waiting result, the whole pipeline holds and
// in_stall rises in the same cycle; out_item stays unchanged until taken.
// Reset empties the pipeline and sets each reciprocal cell size to 1.0.
// The APB registers sit at byte addresses 0, 4 and 8 for x, y and z and
// should only be written while no item is in flight.
module level_set_normal_unit
  import lsn_pkg::*;
#(
  parameter int NUM_DIMS = DEF_NUM_DIMS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_item,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [ADDR_W-1:0]     cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  logic                  en;
  logic [INV_W-1:0]      inv_r [NUM_AXES];
  reg_idx_t              cfg_idx;

  // Configuration registers.
  assign cfg_pready = 1'b1;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        inv_r[i] <= INV_RESET;
      end
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (cfg_idx)
        REG_INV_X: inv_r[0] <= cfg_pwdata;
        REG_INV_Y: inv_r[1] <= cfg_pwdata;
        REG_INV_Z: inv_r[2] <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_INV_X: cfg_prdata = inv_r[0];
      REG_INV_Y: cfg_prdata = inv_r[1];
      REG_INV_Z: cfg_prdata = inv_r[2];
      default:   cfg_prdata = '0;
    endcase
  end

  // The pipeline advances unless a finished item is held by the receiver.
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // Axis lanes.
  logic signed [DATA_W-1:0] lo_v [NUM_AXES];
  logic signed [DATA_W-1:0] hi_v [NUM_AXES];
  logic [MAG_W-1:0]         lmag [NUM_AXES];
  logic                     lneg [NUM_AXES];
  logic [1:0]               lv_r;

  assign lo_v[0] = in_item.x_minus_value;
  assign hi_v[0] = in_item.x_plus_value;
  assign lo_v[1] = in_item.y_minus_value;
  assign hi_v[1] = in_item.y_plus_value;
  assign lo_v[2] = in_item.z_minus_value;
  assign hi_v[2] = in_item.z_plus_value;

  for (genvar d = 0; d < NUM_AXES; d++) begin : g_lane
    if (d < NUM_DIMS) begin : g_on
      lsn_lane u_lane (
        .clk      (clk),
        .en       (en),
        .centre   (in_item.centre_value),
        .minus_val(lo_v[d]),
        .plus_val (hi_v[d]),
        .inv      (inv_r[d]),
        .mag_r    (lmag[d]),
        .neg_r    (lneg[d])
      );
    end else begin : g_off
      assign lmag[d] = '0;
      assign lneg[d] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lv_r <= '0;
    end else if (en) begin
      lv_r <= {lv_r[0], in_valid && !in_stall};
    end
  end

  // Merge: largest magnitude over the lanes.
  logic [MAG_W-1:0] m_r;
  logic [MAG_W-1:0] mag3_r [NUM_AXES];
  logic [NUM_AXES-1:0] neg3_r;
  logic             v3_r;
  logic [MAG_W-1:0] m_nxt;

  always_comb begin
    m_nxt = '0;
    for (int d = 0; d < NUM_AXES; d++) begin
      if (lmag[d] > m_nxt) begin
        m_nxt = lmag[d];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r <= m_nxt;
      for (int d = 0; d < NUM_AXES; d++) begin
        mag3_r[d] <= lmag[d];
        neg3_r[d] <= lneg[d];
      end
    end
  end

  // Shift count that brings the maximum into [2^29, 2^30).
  logic [SHIFT_W-1:0]  lead;
  logic [SHIFT_W-1:0]  lsh_r, rsh_r;
  logic [MAG_W-1:0]    mag4_r [NUM_AXES];
  logic [NUM_AXES-1:0] neg4_r;
  logic                v4_r;

  always_comb begin
    lead = '0;
    for (int b = 0; b < MAG_W; b++) begin
      if (m_r[b]) begin
        lead = SHIFT_W'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lsh_r <= (lead < SHIFT_W'(SMAG_W-1)) ? SHIFT_W'(SMAG_W-1) - lead : '0;
      rsh_r <= (lead > SHIFT_W'(SMAG_W-1)) ? lead - SHIFT_W'(SMAG_W-1) : '0;
      mag4_r <= mag3_r;
      neg4_r <= neg3_r;
    end
  end

  // Apply the common shift to every lane.
  logic [SMAG_W-1:0]   smag5_r [NUM_AXES];
  logic [NUM_AXES-1:0] neg5_r;
  logic                v5_r;
  logic [MAG_W-1:0]    shifted [NUM_AXES];

  always_comb begin
    for (int d = 0; d < NUM_AXES; d++) begin
      shifted[d] = (mag4_r[d] << lsh_r) >> rsh_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int d = 0; d < NUM_AXES; d++) begin
        smag5_r[d] <= shifted[d][SMAG_W-1:0];
      end
      neg5_r <= neg4_r;
    end
  end

  // Squares, then their sum.
  logic [SQ_W-1:0]     sq6_r [NUM_AXES];
  sq_side_t            side6_r, side7_r;
  logic                v6_r, v7_r;
  logic [SUM_W-1:0]    sum7_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int d = 0; d < NUM_AXES; d++) begin
        sq6_r[d]         <= SQ_W'(smag5_r[d]) * SQ_W'(smag5_r[d]);
        side6_r.mag[d]   <= smag5_r[d];
      end
      side6_r.neg <= neg5_r;
      sum7_r      <= SUM_W'(sq6_r[0]) + SUM_W'(sq6_r[1]) + SUM_W'(sq6_r[2]);
      side7_r     <= side6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else if (en) begin
      v3_r <= lv_r[1];
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
    end
  end

  // Length of the scaled gradient.
  logic             sv;
  logic [LEN_W-1:0] len;
  sq_side_t         sside;

  lsn_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (v7_r),
    .sum      (sum7_r),
    .side     (side7_r),
    .out_valid(sv),
    .len      (len),
    .side_out (sside)
  );

  // One divider per component.
  logic [NUM_AXES-1:0] dv, dneg, dzero;
  logic [QUOT_W-1:0]   quot [NUM_AXES];

  for (genvar d = 0; d < NUM_AXES; d++) begin : g_div
    lsn_div u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_valid (sv),
      .mag      (sside.mag[d]),
      .len      (len),
      .neg      (sside.neg[d]),
      .out_valid(dv[d]),
      .quot     (quot[d]),
      .neg_out  (dneg[d]),
      .zero_out (dzero[d])
    );
  end

  // Clamp, set the sign opposite to the gradient, and register the result.
  logic signed [NORM_W-1:0] comp [NUM_AXES];
  logic [QUOT_W-1:0]        n_c;
  out_item_t                out_r;
  logic                     out_valid_r;

  always_comb begin
    for (int d = 0; d < NUM_AXES; d++) begin
      n_c = (quot[d] > UNIT_NORM) ? UNIT_NORM : quot[d];
      if (dzero[0]) begin
        comp[d] = '0;
      end else if (dneg[d]) begin
        comp[d] = NORM_W'(n_c);
      end else begin
        comp[d] = -NORM_W'(n_c);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r.normal_x      <= comp[0];
      out_r.normal_y      <= comp[1];
      out_r.normal_z      <= comp[2];
      out_r.zero_gradient <= dzero[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv[0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule
